// ===== rtl/route_prefix_matcher_core_macros.svh =====
// ----------------------------------------------------------------------------
// route_prefix_matcher_core_macros.svh
// Assertion macros used by the route prefix matcher checker.
// ----------------------------------------------------------------------------
`ifndef ROUTE_PREFIX_MATCHER_CORE_MACROS_SVH
`define ROUTE_PREFIX_MATCHER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define RPM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rpm_pkg
// Types, character codes and helpers for the route prefix matcher.
// ----------------------------------------------------------------------------
package rpm_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_STREAM    = 2'd0,
      OP_LOAD_CHAR = 2'd1,
      OP_LOAD_LEN  = 2'd2
   } op_type;

   // Result word kinds
   typedef enum logic [2:0] {
      KIND_MATCHED   = 3'd0,
      KIND_WILDCARD  = 3'd1,
      KIND_RAW       = 3'd2,
      KIND_PAYLOAD   = 3'd3,
      KIND_DONE      = 3'd4,
      KIND_NOT_FOUND = 3'd5
   } kind_type;

   // Request terminators
   typedef enum logic [1:0] {
      TERM_CRLF = 2'd0,
      TERM_CR   = 2'd1,
      TERM_LF   = 2'd2
   } term_type;

   // Parser modes
   typedef enum logic [1:0] {
      MODE_MATCH   = 2'd0,
      MODE_RAW     = 2'd1,
      MODE_PAYLOAD = 2'd2
   } mode_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EVAL = 1'b1
   } state_type;

   // One result word
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  route_id;
      logic [7:0]  data_byte;
      term_type    terminator;
      logic        last;
   } rsp_word_type;

   // Character codes
   localparam logic [7:0] CHR_PERCENT = 8'h25;
   localparam logic [7:0] CHR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_LF      = 8'h0A;
   localparam logic [7:0] CHR_NUL     = 8'h00;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_UP_A    = 8'h41;
   localparam logic [7:0] CHR_UP_Z    = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // Lowercase A to Z only
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= CHR_UP_A) && (c <= CHR_UP_Z)) ? (c + CASE_OFFSET) : c;
   endfunction

endpackage

// ===== rtl/route_prefix_matcher_core.sv =====
// ----------------------------------------------------------------------------
// route_prefix_matcher_core
// Byte-stream command router: matches lowercased request bytes against a
// pattern store, one stored position row per stream byte.
// ----------------------------------------------------------------------------
//  channel | direction | words                             | handshake
//  req_*   | in        | stream byte or pattern load       | req_valid/req_ready
//  rsp_*   | out       | match, raw, payload, done, not found | rsp_valid/rsp_ready
//
//  A load word is written in the cycle that accepts it. For a stream byte
//  the accept cycle reads one position row of the pattern store, and the
//  next cycle compares it against all routes and updates the parser.
//  Results go to a four-word queue; a new word is taken only while at least
//  two entries are free, so a stalled rsp side holds req_ready low.
//  Reset clears the parser and the lengths at once; the pattern store is
//  not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module route_prefix_matcher_core
   import rpm_pkg::*;
#(
   parameter int NUM_ROUTES  = 16,
   parameter int PATTERN_LEN = 32,
   parameter int RAW_MAX     = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_byte_req,
   input  logic [3:0]  req_route_sel,
   input  logic [4:0]  req_char_pos,
   input  logic [5:0]  req_pat_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kind_type    rsp_kind,
   output logic [3:0]  rsp_route_id,
   output logic [7:0]  rsp_data_byte,
   output term_type    rsp_terminator,
   output logic        rsp_last
);

   localparam int ROUTE_W = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
   localparam int ADDR_W  = $clog2(PATTERN_LEN);
   localparam int LEN_W   = $clog2(PATTERN_LEN + 1);
   localparam int RAW_W   = $clog2(RAW_MAX);

   // Sequencer
   state_type st_ff, st_in;
   logic      req_fire, rd_en, eval_en;

   // Pattern store, one row per character position
   logic [NUM_ROUTES-1:0][7:0] pat_mem_ff [PATTERN_LEN];
   logic [NUM_ROUTES-1:0][7:0] row_ff;
   logic [ADDR_W-1:0]          rd_addr, wr_row;
   logic                       char_wr, len_wr;
   logic [LEN_W-1:0]           len_sat;
   logic [LEN_W-1:0]           len_ff [NUM_ROUTES];

   // Parser state
   logic [NUM_ROUTES-1:0] live_ff, live_in;
   logic [LEN_W-1:0]      pos_ff, pos_in;
   mode_type              mode_ff, mode_in;
   logic [ROUTE_W-1:0]    active_ff, active_in;
   logic [RAW_W-1:0]      raw_ff, raw_in;
   logic                  prev_space_ff, prev_space_in;
   logic                  cr_pend_ff, cr_pend_in;
   logic [7:0]            byte_ff;

   // Lane compare
   logic [7:0]            lc_byte;
   logic [NUM_ROUTES-1:0] base_live, wild_vec, keep_vec, full_vec;
   logic [LEN_W-1:0]      base_pos, pos_inc;
   logic [ROUTE_W-1:0]    wild_idx, full_idx;
   logic                  wild_hit, full_hit, any_keep;

   // Result words
   rsp_word_type w1, w2, push0, push1, head;
   logic         e1, e2;
   logic [1:0]   push_n;

   // Result queue
   rsp_word_type         q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] cnt_ff;
   logic                 rsp_pop;

   assign req_fire = req_valid && req_ready;
   assign rd_en    = req_fire && (req_operation == OP_STREAM);

   // Next state
   always_comb begin
      unique case (st_ff)
         ST_IDLE: st_in = (req_fire && (req_operation == OP_STREAM)) ? ST_EVAL : ST_IDLE;
         ST_EVAL: st_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = (st_ff == ST_IDLE) && (cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
      eval_en   = (st_ff == ST_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // Decode load words
   always_comb begin
      char_wr = req_fire && (req_operation == OP_LOAD_CHAR)
                && (int'(req_route_sel) < NUM_ROUTES) && (int'(req_char_pos) < PATTERN_LEN);
      len_wr  = req_fire && (req_operation == OP_LOAD_LEN)
                && (int'(req_route_sel) < NUM_ROUTES);
      wr_row  = ADDR_W'(req_char_pos);
      len_sat = (int'(req_pat_length) > PATTERN_LEN) ? LEN_W'(PATTERN_LEN)
                                                     : LEN_W'(req_pat_length);
      // a pending CR restarts the parser, so the match starts at row zero
      rd_addr = cr_pend_ff ? '0 : pos_ff[ADDR_W-1:0];
   end

   // Write one character lane, read one whole row
   always_ff @(posedge clock) begin
      if (char_wr) begin
         for (int j = 0; j < NUM_ROUTES; j++) begin
            if (int'(req_route_sel) == j) begin
               pat_mem_ff[wr_row][j] <= req_byte_req;
            end
         end
      end
      if (rd_en) begin
         row_ff <= pat_mem_ff[rd_addr];
      end
   end

   // Pattern lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_ROUTES; j++) begin
            len_ff[j] <= '0;
         end
      end else if (len_wr) begin
         for (int j = 0; j < NUM_ROUTES; j++) begin
            if (int'(req_route_sel) == j) begin
               len_ff[j] <= len_sat;
            end
         end
      end
   end

   // Hold the stream byte for the compare cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byte_ff <= req_byte_req;
      end
   end

   // Compare the row against every live route
   always_comb begin
      logic       alive;
      logic [7:0] pc;
      lc_byte   = to_lower(byte_ff);
      base_live = cr_pend_ff ? '1 : live_ff;
      base_pos  = cr_pend_ff ? '0 : pos_ff;
      pos_inc   = base_pos + 1'b1;
      for (int j = 0; j < NUM_ROUTES; j++) begin
         alive       = base_live[j] && (len_ff[j] != '0) && (base_pos < len_ff[j]);
         pc          = to_lower(row_ff[j]);
         wild_vec[j] = alive && (pc == CHR_PERCENT);
         keep_vec[j] = alive && (pc == lc_byte);
         full_vec[j] = keep_vec[j] && (len_ff[j] == pos_inc);
      end
   end

   // Pick the lowest wildcard and the lowest complete route
   always_comb begin
      wild_idx = '0;
      full_idx = '0;
      for (int j = NUM_ROUTES - 1; j >= 0; j--) begin
         if (wild_vec[j]) begin
            wild_idx = ROUTE_W'(j);
         end
         if (full_vec[j]) begin
            full_idx = ROUTE_W'(j);
         end
      end
      wild_hit = |wild_vec;
      full_hit = |full_vec;
      any_keep = |keep_vec;
   end

   // Advance the parser by one stream byte
   always_comb begin
      mode_in       = mode_ff;
      active_in     = active_ff;
      raw_in        = raw_ff;
      prev_space_in = prev_space_ff;
      pos_in        = pos_ff;
      live_in       = live_ff;
      cr_pend_in    = cr_pend_ff;
      w1            = '0;
      w2            = '0;
      e1            = 1'b0;
      e2            = 1'b0;
      if (eval_en) begin
         cr_pend_in = 1'b0;
         // close the request held open by a pending CR
         if (cr_pend_ff) begin
            e1            = (mode_ff != MODE_MATCH);
            w1.kind       = KIND_DONE;
            w1.route_id   = 4'(active_ff);
            w1.terminator = (byte_ff == CHR_LF) ? TERM_CRLF : TERM_CR;
            mode_in       = MODE_MATCH;
            active_in     = '0;
            raw_in        = '0;
            prev_space_in = 1'b0;
            pos_in        = '0;
            live_in       = '1;
         end
         priority if (cr_pend_ff && (byte_ff == CHR_LF)) begin
            // CRLF already closed
         end else if (byte_ff == CHR_CR) begin
            cr_pend_in = 1'b1;
         end else if ((byte_ff == CHR_LF) || (byte_ff == CHR_NUL)) begin
            e2            = (mode_in != MODE_MATCH);
            w2.kind       = KIND_DONE;
            w2.route_id   = 4'(active_in);
            w2.terminator = TERM_LF;
            mode_in       = MODE_MATCH;
            active_in     = '0;
            raw_in        = '0;
            prev_space_in = 1'b0;
            pos_in        = '0;
            live_in       = '1;
         end else if ((lc_byte == CHR_SPACE) && prev_space_in) begin
            // drop repeated space
         end else begin
            prev_space_in = (lc_byte == CHR_SPACE);
            unique case (mode_in)
               MODE_RAW: begin
                  if (lc_byte == CHR_LBRACE) begin
                     mode_in      = MODE_PAYLOAD;
                     e2           = 1'b1;
                     w2.kind      = KIND_PAYLOAD;
                     w2.data_byte = lc_byte;
                  end else if (raw_in < RAW_W'(RAW_MAX - 1)) begin
                     raw_in       = raw_in + 1'b1;
                     e2           = 1'b1;
                     w2.kind      = KIND_RAW;
                     w2.data_byte = lc_byte;
                  end
               end
               MODE_PAYLOAD: begin
                  e2           = 1'b1;
                  w2.kind      = KIND_PAYLOAD;
                  w2.data_byte = lc_byte;
               end
               MODE_MATCH: begin
                  if (wild_hit) begin
                     live_in      = '0;
                     mode_in      = MODE_RAW;
                     active_in    = wild_idx;
                     raw_in       = RAW_W'(1);
                     e2           = 1'b1;
                     w2.kind      = KIND_WILDCARD;
                     w2.route_id  = 4'(wild_idx);
                     w2.data_byte = lc_byte;
                  end else begin
                     pos_in  = pos_inc;
                     live_in = keep_vec;
                     if (full_hit) begin
                        live_in     = '0;
                        mode_in     = MODE_PAYLOAD;
                        active_in   = full_idx;
                        e2          = 1'b1;
                        w2.kind     = KIND_MATCHED;
                        w2.route_id = 4'(full_idx);
                     end else if (!any_keep) begin
                        e2            = 1'b1;
                        w2.kind       = KIND_NOT_FOUND;
                        mode_in       = MODE_MATCH;
                        active_in     = '0;
                        raw_in        = '0;
                        prev_space_in = 1'b0;
                        pos_in        = '0;
                        live_in       = '1;
                     end
                  end
               end
               default: begin
                  // unused mode code: hold
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '1;
         pos_ff        <= '0;
         mode_ff       <= MODE_MATCH;
         active_ff     <= '0;
         raw_ff        <= '0;
         prev_space_ff <= 1'b0;
         cr_pend_ff    <= 1'b0;
      end else begin
         live_ff       <= live_in;
         pos_ff        <= pos_in;
         mode_ff       <= mode_in;
         active_ff     <= active_in;
         raw_ff        <= raw_in;
         prev_space_ff <= prev_space_in;
         cr_pend_ff    <= cr_pend_in;
      end
   end

   // Pack up to two result words, mark the final one
   always_comb begin
      push0      = e1 ? w1 : w2;
      push1      = w2;
      push0.last = !(e1 && e2);
      push1.last = 1'b1;
      push_n     = (e1 && e2) ? 2'd2 : ((e1 || e2) ? 2'd1 : 2'd0);
   end

   // Result queue
   assign rsp_pop = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + 1'b1] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(rsp_pop);
         cnt_ff    <= cnt_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(rsp_pop);
      end
   end

   assign head           = q_ff[rd_ptr_ff];
   assign rsp_valid      = (cnt_ff != '0);
   assign rsp_kind       = head.kind;
   assign rsp_route_id   = head.route_id;
   assign rsp_data_byte  = head.data_byte;
   assign rsp_terminator = head.terminator;
   assign rsp_last       = head.last;

endmodule

// ===== rtl/rpm_checker.sv =====
// ----------------------------------------------------------------------------
// rpm_checker
// Port-level checks on the route prefix matcher, bound to route_prefix_matcher_core.
// ----------------------------------------------------------------------------
`include "route_prefix_matcher_core_macros.svh"

module rpm_checker
   import rpm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_operation,
   input logic [7:0] req_byte_req,
   input logic [3:0] req_route_sel,
   input logic [4:0] req_char_pos,
   input logic [5:0] req_pat_length,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input kind_type   rsp_kind,
   input logic [3:0] rsp_route_id,
   input logic [7:0] rsp_data_byte,
   input term_type   rsp_terminator,
   input logic       rsp_last
);

   // A stalled result word holds
   `RPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_route_id) && $stable(rsp_data_byte) && $stable(rsp_last), "stalled result word changed")

   // A stream word blocks the next one for its compare cycle
   `RPM_ASSERT_NEXT(a_stream_gap, clock, reset, req_valid && req_ready && (req_operation == OP_STREAM), !req_ready, "stream word taken during compare cycle")

   // Only character-carrying kinds show a byte
   `RPM_ASSERT_NOW(a_data_zero, clock, reset, rsp_valid && (rsp_kind != KIND_WILDCARD) && (rsp_kind != KIND_RAW) && (rsp_kind != KIND_PAYLOAD), rsp_data_byte == 8'd0, "data byte on a kind without one")

   // Terminator only on request done, route only on matched, wildcard and done words
   `RPM_ASSERT_NOW(a_term_zero, clock, reset, rsp_valid && (rsp_kind != KIND_DONE), rsp_terminator == TERM_CRLF, "terminator on a kind without one")

   `RPM_ASSERT_NOW(a_route_zero, clock, reset, rsp_valid && ((rsp_kind == KIND_RAW) || (rsp_kind == KIND_PAYLOAD) || (rsp_kind == KIND_NOT_FOUND)), rsp_route_id == 4'd0, "route on a kind without one")

endmodule

bind route_prefix_matcher_core rpm_checker u_rpm_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for route_prefix_matcher_core. A short table of
// directed words exercises pattern loads, wildcard and full matches, raw
// overflow, space folding and every terminator. Random pattern loads and
// well-formed requests, with noise mixed in, follow. Result words are checked
// against a behavioural model in this bench, or against a typed row's word.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rpm_pkg::*;

   localparam int ROUTES       = 16;
   localparam int PAT_SLOTS    = 32;
   localparam int RAW_LIMIT    = 64;
   localparam int ITEM_TARGET  = 900;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 150;
   localparam int REPORT_MAX   = 10;

   // Operation code the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation  = OP_STREAM;
   logic [7:0] req_byte_req   = 8'h00;
   logic [3:0] req_route_sel  = 4'd0;
   logic [4:0] req_char_pos   = 5'd0;
   logic [5:0] req_pat_length = 6'd0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   kind_type   rsp_kind;
   logic [3:0] rsp_route_id;
   logic [7:0] rsp_data_byte;
   term_type   rsp_terminator;
   logic       rsp_last;

   route_prefix_matcher_core #(
      .NUM_ROUTES  (ROUTES),
      .PATTERN_LEN (PAT_SLOTS),
      .RAW_MAX     (RAW_LIMIT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_byte_req   (req_byte_req),
      .req_route_sel  (req_route_sel),
      .req_char_pos   (req_char_pos),
      .req_pat_length (req_pat_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_route_id   (rsp_route_id),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_terminator (rsp_terminator),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Router state as the model sees it
   logic [7:0]        pat_chars [ROUTES][PAT_SLOTS];
   logic [5:0]        pat_len [ROUTES];
   bit                written [ROUTES][PAT_SLOTS];
   logic [ROUTES-1:0] live;
   logic [5:0]        match_at;
   mode_type          parse_mode;
   logic [3:0]        owner;
   logic [6:0]        raw_seen;
   logic              space_run;
   logic              cr_held;

   rsp_word_type step_words[$];
   rsp_word_type pending_words[$];

   int words_sent    = 0;
   int words_checked = 0;
   int bad_words     = 0;
   int cycles        = 0;
   bit draining      = 1'b0;

   // One row of the directed table
   typedef struct {
      logic [1:0] op;
      logic [7:0] data;
      logic [3:0] sel;
      logic [4:0] pos;
      logic [5:0] len;
      int         reps;
      bit         typed;
      kind_type   kind;
      logic [3:0] route;
      term_type   term;
   } plan_row;

   plan_row plan [24] = '{
      // no routes after reset: anything is not found
      '{OP_STREAM,    8'h78,       4'd0,  5'd0,  6'd0,  1,  1'b1, KIND_NOT_FOUND, 4'd0,  TERM_CRLF},
      '{OP_UNUSED,    8'hFF,       4'd15, 5'd31, 6'd63, 1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      // route 15 "G%", route 0 "gx"
      '{OP_LOAD_CHAR, 8'h47,       4'd15, 5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_LOAD_CHAR, CHR_PERCENT, 4'd15, 5'd1,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_LOAD_LEN,  8'h00,       4'd15, 5'd0,  6'd2,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_LOAD_CHAR, 8'h67,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_LOAD_CHAR, 8'h78,       4'd0,  5'd1,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_LOAD_LEN,  8'h00,       4'd0,  5'd0,  6'd2,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      // wildcard beats the full match at the same position
      '{OP_STREAM,    8'h47,       4'd3,  5'd7,  6'd9,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    8'h58,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    8'hFF,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    CHR_SPACE,   4'd0,  5'd0,  6'd0,  2,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      // run past the raw limit, then open the payload
      '{OP_STREAM,    8'h61,       4'd0,  5'd0,  6'd0,  66, 1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    CHR_LBRACE,  4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    CHR_CR,      4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    CHR_LF,      4'd0,  5'd0,  6'd0,  1,  1'b1, KIND_DONE,      4'd15, TERM_CRLF},
      // route 0 shortened to "g": full match on the first byte
      '{OP_LOAD_LEN,  8'h00,       4'd0,  5'd0,  6'd1,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    8'h67,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    8'h51,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      // lone CR then a byte: done, then not found
      '{OP_STREAM,    CHR_CR,      4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    8'h7A,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    8'h67,       4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF},
      '{OP_STREAM,    CHR_NUL,     4'd0,  5'd0,  6'd0,  1,  1'b1, KIND_DONE,      4'd0,  TERM_LF},
      // unresolved request ends silently
      '{OP_STREAM,    CHR_LF,      4'd0,  5'd0,  6'd0,  1,  1'b0, KIND_MATCHED,   4'd0,  TERM_CRLF}
   };

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= CHR_UP_A && c <= CHR_UP_Z) ? c + CASE_OFFSET : c;
   endfunction

   function automatic void put_word(input kind_type k, input logic [3:0] r,
                                    input logic [7:0] d, input term_type t);
      rsp_word_type w;
      w.kind       = k;
      w.route_id   = r;
      w.data_byte  = d;
      w.terminator = t;
      w.last       = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void clear_parser();
      live       = '1;
      match_at   = '0;
      parse_mode = MODE_MATCH;
      owner      = '0;
      raw_seen   = '0;
      space_run  = 1'b0;
      cr_held    = 1'b0;
   endfunction

   function automatic void close_request(input term_type t);
      if (parse_mode != MODE_MATCH) put_word(KIND_DONE, owner, 8'h00, t);
      clear_parser();
   endfunction

   // Advance the router model by one word and collect the result words it gives
   function automatic void track_router(input logic [1:0] op, input logic [7:0] b,
                                        input logic [3:0] sel, input logic [4:0] pos,
                                        input logic [5:0] len);
      logic [7:0]   c;
      logic [7:0]   p;
      int           wild;
      int           full;
      bit           any;
      bit           done;
      rsp_word_type w;
      step_words.delete();
      wild = -1;
      full = -1;
      any  = 1'b0;
      done = 1'b0;
      c    = fold_case(b);

      // loads touch only the pattern store
      if (op == OP_LOAD_CHAR) begin
         pat_chars[sel][pos] = b;
         written[sel][pos]   = 1'b1;
         done = 1'b1;
      end else if (op == OP_LOAD_LEN) begin
         pat_len[sel] = (len > PAT_SLOTS) ? 6'(PAT_SLOTS) : len;
         done = 1'b1;
      end else if (op != OP_STREAM) begin
         done = 1'b1;
      end

      // resolve a held CR
      if (!done && cr_held) begin
         cr_held = 1'b0;
         if (b == CHR_LF) begin
            close_request(TERM_CRLF);
            done = 1'b1;
         end else begin
            close_request(TERM_CR);
         end
      end
      if (!done && b == CHR_CR) begin
         cr_held = 1'b1;
         done = 1'b1;
      end
      if (!done && (b == CHR_LF || b == CHR_NUL)) begin
         close_request(TERM_LF);
         done = 1'b1;
      end

      // fold runs of spaces into one
      if (!done) begin
         if (c == CHR_SPACE) begin
            if (space_run) done = 1'b1;
            space_run = 1'b1;
         end else begin
            space_run = 1'b0;
         end
      end

      if (!done && parse_mode == MODE_RAW) begin
         if (c == CHR_LBRACE) begin
            parse_mode = MODE_PAYLOAD;
            put_word(KIND_PAYLOAD, 4'd0, c, TERM_CRLF);
         end else if (raw_seen < RAW_LIMIT - 1) begin
            raw_seen = raw_seen + 7'd1;
            put_word(KIND_RAW, 4'd0, c, TERM_CRLF);
         end
         done = 1'b1;
      end
      if (!done && parse_mode == MODE_PAYLOAD) begin
         put_word(KIND_PAYLOAD, 4'd0, c, TERM_CRLF);
         done = 1'b1;
      end

      // match against every live route; the first wildcard takes over at once
      if (!done) begin
         for (int j = 0; j < ROUTES; j++) begin
            if (wild < 0 && live[j]) begin
               if (pat_len[j] == 6'd0 || match_at >= pat_len[j]) begin
                  live[j] = 1'b0;
               end else begin
                  p = fold_case(pat_chars[j][match_at[4:0]]);
                  if (p == CHR_PERCENT) wild = j;
                  else live[j] = (p == c);
               end
            end
         end
         if (wild >= 0) begin
            live       = '0;
            parse_mode = MODE_RAW;
            owner      = 4'(wild);
            raw_seen   = 7'd1;
            put_word(KIND_WILDCARD, owner, c, TERM_CRLF);
         end else begin
            match_at = match_at + 6'd1;
            for (int j = 0; j < ROUTES; j++) begin
               if (live[j]) begin
                  any = 1'b1;
                  if (full < 0 && pat_len[j] == match_at) full = j;
               end
            end
            if (full >= 0) begin
               live       = '0;
               parse_mode = MODE_PAYLOAD;
               owner      = 4'(full);
               put_word(KIND_MATCHED, owner, 8'h00, TERM_CRLF);
            end else if (!any) begin
               put_word(KIND_NOT_FOUND, 4'd0, 8'h00, TERM_CRLF);
               clear_parser();
            end
         end
      end

      // flag the final word of this step
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.last = 1'b1;
         step_words.push_back(w);
      end
   endfunction

   // Mostly short pauses, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pattern_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return CHR_PERCENT;
      if (r < 10) return CHR_SPACE;
      if (r < 14) return 8'h2F;
      if (r < 17) return 8'($urandom_range(0, 255));
      if (r < 30) return 8'($urandom_range(CHR_UP_A, CHR_UP_A + 3));
      return 8'($urandom_range(8'h61, 8'h64));
   endfunction

   // Offer one word, hold it until taken, then predict its results
   task automatic offer(input logic [1:0] op, input logic [7:0] b, input logic [3:0] sel,
                        input logic [4:0] pos, input logic [5:0] len, input bit keep = 1'b1);
      int gap;
      gap = ((words_sent / 64) % 4 == 1) ? 0 : idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_operation  = op;
      req_byte_req   = b;
      req_route_sel  = sel;
      req_char_pos   = pos;
      req_pat_length = len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_router(op, b, sel, pos, len);
      if (keep) foreach (step_words[k]) pending_words.push_back(step_words[k]);
      words_sent++;
   endtask

   // Stream byte with the unused fields scrambled
   task automatic stream(input logic [7:0] b);
      offer(OP_STREAM, b, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
            6'($urandom_range(0, 63)));
   endtask

   // Write a fresh pattern of n characters, then its length
   task automatic load_route(input logic [3:0] sel, input int n);
      for (int i = 0; i < n; i++) offer(OP_LOAD_CHAR, pattern_byte(), sel, 5'(i), 6'd0);
      offer(OP_LOAD_LEN, 8'h00, sel, 5'd0, 6'(n));
   endtask

   initial begin : stimulus
      rsp_word_type known;
      int           pick;
      int           r;
      int           n;
      int           body;
      int           tries;
      logic [7:0]   b;
      logic [3:0]   sel;

      for (int j = 0; j < ROUTES; j++) pat_len[j] = 6'd0;
      clear_parser();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (plan[i]) begin
         for (int k = 0; k < plan[i].reps; k++) begin
            offer(plan[i].op, plan[i].data, plan[i].sel, plan[i].pos, plan[i].len,
                  !plan[i].typed);
            if (plan[i].typed) begin
               known.kind       = plan[i].kind;
               known.route_id   = plan[i].route;
               known.data_byte  = 8'h00;
               known.terminator = plan[i].term;
               known.last       = 1'b1;
               pending_words.push_back(known);
            end
         end
      end

      // route 14 gets all positions and an oversized length that saturates
      for (int i = 0; i < PAT_SLOTS; i++)
         offer(OP_LOAD_CHAR, pattern_byte(), 4'd14, 5'(i), 6'd0);
      offer(OP_LOAD_LEN, 8'h00, 4'd14, 5'd0, 6'd63);
      for (int j = 0; j < ROUTES; j++)
         if (j != 14) load_route(4'(j), $urandom_range(1, 6));

      // random part, up to the total word count
      while (words_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            load_route(4'($urandom_range(0, 15)),
                       ($urandom_range(0, 9) == 0) ? PAT_SLOTS : $urandom_range(1, 6));
         end else if (pick < 12) begin
            sel = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 0) begin
               b = ($urandom_range(0, 1) == 0) ? pattern_byte() : 8'($urandom_range(0, 255));
               offer(OP_LOAD_CHAR, b, sel, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
            end else begin
               // only lengths over positions already written
               n = 0;
               while (n < PAT_SLOTS && written[sel][n]) n++;
               offer(OP_LOAD_LEN, 8'($urandom_range(0, 255)), sel, 5'($urandom_range(0, 31)),
                     6'($urandom_range(0, n)));
            end
         end else if (pick < 20) begin
            if ($urandom_range(0, 7) == 0)
               offer(OP_UNUSED, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
            else
               stream(8'($urandom_range(0, 255)));
         end else begin
            // well-formed request: walk a live pattern up to any wildcard
            r = $urandom_range(0, ROUTES - 1);
            tries = 0;
            while (pat_len[r] == 6'd0 && tries < 32) begin
               r = $urandom_range(0, ROUTES - 1);
               tries++;
            end
            for (int i = 0; i < pat_len[r]; i++) begin
               b = pat_chars[r][i];
               if (fold_case(b) == CHR_PERCENT) break;
               if (b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 2) == 0) b = b - CASE_OFFSET;
               if ($urandom_range(0, 19) == 0) b = 8'($urandom_range(0, 255));
               stream(b);
            end

            // body: mostly short, now and then long enough to overflow raw
            body = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 80) : $urandom_range(0, 6);
            for (int i = 0; i < body; i++) begin
               pick = $urandom_range(0, 99);
               if (body < 10 && pick < 8) begin
                  b = CHR_LBRACE;
               end else if (pick < 18) begin
                  b = CHR_SPACE;
               end else begin
                  b = 8'($urandom_range(1, 255));
                  while (b == CHR_CR || b == CHR_LF) b = 8'($urandom_range(1, 255));
               end
               stream(b);
            end

            // end of request, lone CR lets the next byte close it
            case ($urandom_range(0, 4))
               0: begin
                  stream(CHR_CR);
                  stream(CHR_LF);
               end
               1: stream(CHR_CR);
               2: stream(CHR_LF);
               3: stream(CHR_NUL);
               default: begin
                  stream(CHR_CR);
                  stream(CHR_CR);
               end
            endcase
         end
      end

      @(negedge clock);
      req_valid = 1'b0;

      // drain, then watch for strays
      while (pending_words.size() != 0) @(posedge clock);
      draining = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_words == 0 && pending_words.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off to back the block up
   initial begin : rsp_side
      int run_left;
      int stall_left;
      bit held;
      run_left   = 0;
      stall_left = 0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && words_checked >= HOLD_AFTER) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
            run_left   = 0;
         end
         if (draining) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready  = 1'b0;
            stall_left = stall_left - 1;
         end else if (run_left > 0 || (cycles / 512) % 4 == 2) begin
            rsp_ready = 1'b1;
            if (run_left > 0) run_left = run_left - 1;
         end else begin
            run_left   = $urandom_range(1, 24);
            stall_left = idle_gap();
            rsp_ready  = (stall_left == 0);
            if (stall_left > 0) stall_left = stall_left - 1;
         end
      end
   end

   // Compare each taken result word with the oldest prediction
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (pending_words.size() == 0) begin
            bad_words++;
            if (bad_words <= REPORT_MAX)
               $display("word %0d unexpected: k%0d r%0d d%02h t%0d l%0b", words_checked,
                        rsp_kind, rsp_route_id, rsp_data_byte, rsp_terminator, rsp_last);
         end else begin
            want = pending_words.pop_front();
            if (rsp_kind !== want.kind || rsp_route_id !== want.route_id ||
                rsp_data_byte !== want.data_byte || rsp_terminator !== want.terminator ||
                rsp_last !== want.last) begin
               bad_words++;
               if (bad_words <= REPORT_MAX)
                  $display("word %0d exp k%0d r%0d d%02h t%0d l%0b got k%0d r%0d d%02h t%0d l%0b",
                           words_checked, want.kind, want.route_id, want.data_byte,
                           want.terminator, want.last, rsp_kind, rsp_route_id,
                           rsp_data_byte, rsp_terminator, rsp_last);
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top failed");
      $finish;
   end

endmodule

// ===== route_prefix_matcher_core.f =====
+incdir+rtl
rtl/rpm_pkg.sv
rtl/route_prefix_matcher_core.sv
rtl/rpm_checker.sv
tb/tb_top.sv
